// File: src/tmi_pkg.sv
// ----------------------------------------------------------------------------
// Tape machine interpreter package
// Item types, opcodes, status codes, program characters and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmi_pkg;

   localparam int TMI_PROGRAM_DEPTH = 1024;
   localparam int TMI_TAPE_DEPTH    = 4096;
   localparam int TMI_CELL_BITS     = 32;

   // Opcodes of an input item.
   localparam logic [1:0] OP_APPEND  = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_STEP    = 2'd3;

   // Run status codes of a result item.
   localparam logic [1:0] RUN_ACTIVE      = 2'd0;
   localparam logic [1:0] RUN_DONE        = 2'd1;
   localparam logic [1:0] RUN_BRACKET_ERR = 2'd2;
   localparam logic [1:0] RUN_STORE_FULL  = 2'd3;

   // Program characters.
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_INC   = 8'h2B;
   localparam logic [7:0] CH_DEC   = 8'h2D;
   localparam logic [7:0] CH_IN    = 8'h2C;
   localparam logic [7:0] CH_OUT   = 8'h2E;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] code_char;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_char;
      logic       in_taken;
      logic [1:0] run_status;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic scan_fwd;
      logic scan_bwd;
      logic clearing;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic runnable;
      logic go_fwd;
      logic go_bwd;
      logic scan_done;
      logic clear_last;
   } sts_type;

endpackage

// File: src/tmi_ctrl.sv
// ----------------------------------------------------------------------------
// Tape machine controller
// Sequences the tape clearing pass, item acceptance, instruction execution
// and bracket scans, and raises the result strobe.
// ----------------------------------------------------------------------------
module tmi_ctrl
   import tmi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] opcode,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCAN_F,
      S_SCAN_B
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_strobe_ff, rsp_strobe_in;

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      cmd           = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clearing = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (opcode == OP_STEP && sts.runnable) begin
                  state_in = S_EXEC;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.go_fwd) begin
               state_in = S_SCAN_F;
            end else if (sts.go_bwd) begin
               state_in = S_SCAN_B;
            end else begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
            end
         end
         S_SCAN_F: begin
            cmd.scan_fwd = 1'b1;
            if (sts.scan_done) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
            end
         end
         S_SCAN_B: begin
            cmd.scan_bwd = 1'b1;
            if (sts.scan_done) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

endmodule

// File: src/tmi_datapath.sv
// ----------------------------------------------------------------------------
// Tape machine datapath
// Program store, tape memory, program counter, cell pointer, bracket scan
// index and depth, and the result fields.
// ----------------------------------------------------------------------------
module tmi_datapath
   import tmi_pkg::*;
#(
   parameter int PROGRAM_DEPTH = TMI_PROGRAM_DEPTH,
   parameter int TAPE_DEPTH    = TMI_TAPE_DEPTH,
   parameter int CELL_BITS     = TMI_CELL_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_item,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_item
);

   localparam int AW = $clog2(PROGRAM_DEPTH);
   localparam int PW = AW + 1;
   localparam int TW = $clog2(TAPE_DEPTH);
   localparam int CW = CELL_BITS;

   logic [7:0]    prog_mem_ff [PROGRAM_DEPTH];
   logic [CW-1:0] tape_mem_ff [TAPE_DEPTH];

   logic [PW-1:0] len_ff, len_in;
   logic [PW-1:0] pc_ff, pc_in;
   logic [TW-1:0] cp_ff, cp_in;
   logic          err_ff, err_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic [PW-1:0] j_ff, j_in;
   logic [PW-1:0] lvl_ff, lvl_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          full_ff, full_in;
   logic          valid_ff, valid_in;
   logic [7:0]    char_ff, char_in;
   logic          taken_ff, taken_in;

   logic [7:0]    prog_q_ff;
   logic [CW-1:0] tape_q_ff;

   logic          prog_we;
   logic [AW-1:0] prog_ra;
   logic          tape_we;
   logic [TW-1:0] tape_wa;
   logic [CW-1:0] tape_wd;
   logic [PW-1:0] lvl_next;
   logic          tape_zero;

   assign tape_zero = (tape_q_ff == '0);

   always_comb begin
      len_in     = len_ff;
      pc_in      = pc_ff;
      cp_in      = cp_ff;
      err_in     = err_ff;
      clr_in     = clr_ff;
      j_in       = j_ff;
      lvl_in     = lvl_ff;
      in_byte_in = in_byte_ff;
      full_in    = full_ff;
      valid_in   = valid_ff;
      char_in    = char_ff;
      taken_in   = taken_ff;
      prog_we    = 1'b0;
      tape_we    = 1'b0;
      tape_wa    = cp_ff;
      tape_wd    = tape_q_ff;
      sts        = '0;
      lvl_next   = lvl_ff;

      if (prog_q_ff == CH_OPEN) begin
         lvl_next = cmd.scan_fwd ? lvl_ff + PW'(1) : lvl_ff - PW'(1);
      end else if (prog_q_ff == CH_CLOSE) begin
         lvl_next = cmd.scan_fwd ? lvl_ff - PW'(1) : lvl_ff + PW'(1);
      end

      if (cmd.clearing) begin
         tape_we = 1'b1;
         tape_wa = clr_ff;
         tape_wd = '0;
         clr_in  = clr_ff + TW'(1);
      end

      if (cmd.accept) begin
         in_byte_in = req_item.in_byte;
         full_in    = (req_item.opcode == OP_APPEND) && (len_ff == PW'(PROGRAM_DEPTH));
         valid_in   = 1'b0;
         char_in    = '0;
         taken_in   = 1'b0;
         case (req_item.opcode)
            OP_APPEND: begin
               if (len_ff != PW'(PROGRAM_DEPTH)) begin
                  prog_we = 1'b1;
                  len_in  = len_ff + PW'(1);
               end
            end
            OP_CLEAR: begin
               len_in = '0;
               pc_in  = '0;
               err_in = 1'b0;
            end
            OP_RESTART: begin
               pc_in  = '0;
               err_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.exec) begin
         case (prog_q_ff)
            CH_RIGHT: begin
               cp_in = (cp_ff == TW'(TAPE_DEPTH - 1)) ? '0 : cp_ff + TW'(1);
               pc_in = pc_ff + PW'(1);
            end
            CH_LEFT: begin
               cp_in = (cp_ff == '0) ? TW'(TAPE_DEPTH - 1) : cp_ff - TW'(1);
               pc_in = pc_ff + PW'(1);
            end
            CH_INC: begin
               tape_we = 1'b1;
               tape_wd = tape_q_ff + CW'(1);
               pc_in   = pc_ff + PW'(1);
            end
            CH_DEC: begin
               tape_we = 1'b1;
               tape_wd = tape_q_ff - CW'(1);
               pc_in   = pc_ff + PW'(1);
            end
            CH_IN: begin
               tape_we  = 1'b1;
               tape_wd  = CW'(in_byte_ff);
               taken_in = 1'b1;
               pc_in    = pc_ff + PW'(1);
            end
            CH_OUT: begin
               valid_in = 1'b1;
               char_in  = tape_q_ff[7:0];
               pc_in    = pc_ff + PW'(1);
            end
            CH_OPEN: begin
               if (!tape_zero) begin
                  pc_in = pc_ff + PW'(1);
               end else if (pc_ff + PW'(1) >= len_ff) begin
                  err_in = 1'b1;
               end else begin
                  j_in       = pc_ff + PW'(1);
                  lvl_in     = PW'(1);
                  sts.go_fwd = 1'b1;
               end
            end
            CH_CLOSE: begin
               if (tape_zero) begin
                  pc_in = pc_ff + PW'(1);
               end else if (pc_ff == '0) begin
                  err_in = 1'b1;
               end else begin
                  j_in       = pc_ff - PW'(1);
                  lvl_in     = PW'(1);
                  sts.go_bwd = 1'b1;
               end
            end
            default: begin
               pc_in = pc_ff + PW'(1);
            end
         endcase
      end

      // The character at j was fetched in the previous cycle.
      if (cmd.scan_fwd) begin
         if (lvl_next == '0) begin
            pc_in         = j_ff + PW'(1);
            sts.scan_done = 1'b1;
         end else if (j_ff + PW'(1) >= len_ff) begin
            err_in        = 1'b1;
            sts.scan_done = 1'b1;
         end else begin
            j_in   = j_ff + PW'(1);
            lvl_in = lvl_next;
         end
      end

      if (cmd.scan_bwd) begin
         if (lvl_next == '0) begin
            pc_in         = j_ff + PW'(1);
            sts.scan_done = 1'b1;
         end else if (j_ff == '0) begin
            err_in        = 1'b1;
            sts.scan_done = 1'b1;
         end else begin
            j_in   = j_ff - PW'(1);
            lvl_in = lvl_next;
         end
      end

      sts.runnable   = !err_ff && (pc_ff < len_ff);
      sts.clear_last = (clr_ff == TW'(TAPE_DEPTH - 1));
   end

   assign prog_ra = (cmd.exec || cmd.scan_fwd || cmd.scan_bwd) ? j_in[AW-1:0] : pc_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem_ff[len_ff[AW-1:0]] <= req_item.code_char;
      end
      prog_q_ff <= prog_mem_ff[prog_ra];
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem_ff[tape_wa] <= tape_wd;
      end
      tape_q_ff <= tape_mem_ff[cp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         pc_ff  <= '0;
         cp_ff  <= '0;
         err_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         len_ff <= len_in;
         pc_ff  <= pc_in;
         cp_ff  <= cp_in;
         err_ff <= err_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff       <= j_in;
      lvl_ff     <= lvl_in;
      in_byte_ff <= in_byte_in;
      full_ff    <= full_in;
      valid_ff   <= valid_in;
      char_ff    <= char_in;
      taken_ff   <= taken_in;
   end

   always_comb begin
      rsp_item.out_valid = valid_ff;
      rsp_item.out_char  = char_ff;
      rsp_item.in_taken  = taken_ff;
      if (full_ff) begin
         rsp_item.run_status = RUN_STORE_FULL;
      end else if (err_ff) begin
         rsp_item.run_status = RUN_BRACKET_ERR;
      end else if (pc_ff >= len_ff) begin
         rsp_item.run_status = RUN_DONE;
      end else begin
         rsp_item.run_status = RUN_ACTIVE;
      end
   end

endmodule

// File: src/tape_machine_interpreter.sv
// ----------------------------------------------------------------------------
// Tape machine interpreter
// Append, clear, restart and single-step items against a program store and a
// tape of wrapping cells; one result item for every input item.
// ----------------------------------------------------------------------------
// Append, clear, restart and a step that cannot run: result in the cycle after
// the accept, busy stays low, so one item per cycle.
// A plain instruction: fetched on accept and executed in S_EXEC, with the wait set by
// the registered reads of the program store and the tape (a fetch, then an execute).
// A bracket jump: after the execute step, S_SCAN_F or S_SCAN_B scans the program.
// After reset, busy is high while the tape is zeroed.
// Results cannot be held off: rsp_strobe marks each for one cycle.
module tape_machine_interpreter
   import tmi_pkg::*;
#(
   parameter int PROGRAM_DEPTH = TMI_PROGRAM_DEPTH,
   parameter int TAPE_DEPTH    = TMI_TAPE_DEPTH,
   parameter int CELL_BITS     = TMI_CELL_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type cmd;
   sts_type sts;

   tmi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .opcode     (req_item.opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   tmi_datapath #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH),
      .TAPE_DEPTH    (TAPE_DEPTH),
      .CELL_BITS     (CELL_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

// File: src/tmi_checker.sv
// ----------------------------------------------------------------------------
// Tape machine interpreter checker
// Port-level properties of the interpreter, bound to the top level.
// ----------------------------------------------------------------------------
module tmi_props
   import tmi_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // The tape clearing pass keeps the block busy right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("block not busy after reset");

   // Items other than a step finish in the cycle after they are accepted.
   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode != OP_STEP) |=> (rsp_strobe && !busy))
      else $error("missing result for a non-step item");

   // A result follows either an accept or a busy cycle.
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("result without a pending item");

   // Output and input flags only come from an executed instruction.
   a_flags_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.out_valid || rsp_item.in_taken)) |->
         (!(rsp_item.out_valid && rsp_item.in_taken) &&
          (rsp_item.run_status == RUN_ACTIVE || rsp_item.run_status == RUN_DONE)))
      else $error("output or input flag on a step that did not execute");

endmodule

bind tape_machine_interpreter tmi_props u_checker (.*);
